// ===== rtl/core/round_robin_reentrant_session_lock_assert.svh =====
// Assertion helpers for the session lock. They expect clk and rst_n in scope.
`ifndef ROUND_ROBIN_REENTRANT_SESSION_LOCK_ASSERT_SVH
`define ROUND_ROBIN_REENTRANT_SESSION_LOCK_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define RRSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("session lock check failed (same cycle)");

// Next-cycle implication, ignored while reset is asserted.
`define RRSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("session lock check failed (next cycle)");

`endif

// ===== rtl/core/rrsl_pkg.sv =====
`default_nettype none

package rrsl_pkg;

  // The session field is four bits wide, so at most sixteen ids can be named.
  localparam int ID_W    = 4;
  localparam int ID_SPAN = 16;

  typedef enum logic [2:0] {
    CMD_ACQUIRE         = 3'd0,
    CMD_WAKE_ACQUIRE    = 3'd1,
    CMD_RELEASE         = 3'd2,
    CMD_YIELD_WAIT      = 3'd3,
    CMD_RESUME          = 3'd4,
    CMD_RETIRE          = 3'd5,
    CMD_QUERY           = 3'd6,
    CMD_LENIENT_RELEASE = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_MUST_WAIT  = 3'd1,
    STAT_NOT_HOLDER = 3'd2,
    STAT_ZERO_DEPTH = 3'd3,
    STAT_OVERFLOW   = 3'd4
  } status_t;

  // Stored per-session state.
  typedef enum logic [1:0] {
    SS_ABSENT   = 2'd0,
    SS_RUNNABLE = 2'd1,
    SS_RUNNING  = 2'd2,
    SS_WAITING  = 2'd3
  } sess_st_t;

  // Session state as reported on the result channel.
  typedef enum logic [1:0] {
    RPT_RUNNABLE = 2'd0,
    RPT_RUNNING  = 2'd1,
    RPT_WAITING  = 2'd2
  } rpt_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] session;
  } in_item_t;

  typedef struct packed {
    logic            granted;
    status_t         status;
    logic            holder_valid;
    logic [ID_W-1:0] holder_session;
    rpt_t            session_status;
    logic            next_valid;
    logic [ID_W-1:0] next_session;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] idx;
  } pick_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrsl_chan_if.sv =====
`default_nettype none

interface rrsl_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rrsl_pick.sv =====
`default_nettype none

// Rotating priority pick: lowest set id above last, else lowest set id.
module rrsl_pick #(
  parameter int N = 16
) (
  input  wire logic [N-1:0]              mask,
  input  wire logic [rrsl_pkg::ID_W-1:0] last,
  output rrsl_pkg::pick_t                res
);

  logic [N-1:0] above;
  logic [N-1:0] sel;
  logic [N-1:0] low;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      above[i] = mask[i] && (rrsl_pkg::ID_W'(i) > last);
    end
    sel = (|above) ? above : mask;
    // Isolate the lowest set bit, then turn the one-hot word into an index.
    low = sel & (~sel + N'(1));
    res.valid = |mask;
    res.idx   = '0;
    for (int i = 0; i < N; i++) begin
      if (low[i]) begin
        res.idx = res.idx | rrsl_pkg::ID_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/round_robin_reentrant_session_lock.sv =====
`default_nettype none

// Channel  Dir  Beat contents
// in_ch    in   cmd, session
// out_ch   out  granted, status, holder_valid, holder_session, session_status,
//                next_valid, next_session
//
// One command enters per cycle unless the result stalls; its result is offered after
// it passes the input register, one pass of decode, rotating pick and state update,
// and the result register. Each command sees the state left by the one before.
// Reset (rst_n low, synchronous) marks every session absent and frees the lock.
// A stalled result stalls the input register only; input stays open while the
// input register is empty or moving on.

`include "round_robin_reentrant_session_lock_assert.svh"

module round_robin_reentrant_session_lock #(
  parameter int MAX_SESSIONS = 16,
  parameter int DEPTH_BITS   = 8
) (
  input wire logic   clk,
  input wire logic   rst_n,
  rrsl_chan_if.sink   in_ch,
  rrsl_chan_if.source out_ch
);

  localparam int NUM_SLOTS = (MAX_SESSIONS < rrsl_pkg::ID_SPAN) ? MAX_SESSIONS
                                                                 : rrsl_pkg::ID_SPAN;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [6:0] MAX_S7 = 7'(MAX_SESSIONS);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

  logic                      in_vld_r;
  rrsl_pkg::in_item_t        in_item_r;
  rrsl_pkg::sess_st_t        st_r   [NUM_SLOTS];
  rrsl_pkg::sess_st_t        st_nxt [NUM_SLOTS];
  logic                      hv_r, hv_nxt;
  logic [rrsl_pkg::ID_W-1:0] holder_r, holder_nxt;
  logic [DEPTH_BITS-1:0]     depth_r, depth_nxt;
  logic [rrsl_pkg::ID_W-1:0] last_r, last_nxt;
  logic                      out_vld_r;
  rrsl_pkg::out_item_t       out_item_r, out_nxt;

  logic                      advance;
  rrsl_pkg::cmd_t            cmd;
  logic [rrsl_pkg::ID_W-1:0] sid;
  logic                      id_ok;
  logic [SLOT_W-1:0]         slot;
  rrsl_pkg::sess_st_t        st_cur;
  logic                      is_holder;
  logic [NUM_SLOTS-1:0]      req_mask;
  logic [NUM_SLOTS-1:0]      post_mask;
  rrsl_pkg::pick_t           pick_req;
  rrsl_pkg::pick_t           pick_post;
  logic                      try_grant;
  logic                      try_drop;
  logic [DEPTH_BITS-1:0]     depth_dec;
  rrsl_pkg::status_t         status;

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.payload = out_item_r;

  assign cmd       = in_item_r.cmd;
  assign sid       = in_item_r.session;
  assign id_ok     = {3'b000, sid} < MAX_S7;
  assign slot      = sid[SLOT_W-1:0];
  assign st_cur    = st_r[slot];
  assign is_holder = hv_r && (holder_r == sid);
  assign depth_dec = depth_r - DEPTH_BITS'(1);

  // Runnable sessions, with the requester counted when it is runnable or absent.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      req_mask[i] = (st_r[i] == rrsl_pkg::SS_RUNNABLE) ||
                    (id_ok && (slot == SLOT_W'(i)) && (st_r[i] == rrsl_pkg::SS_ABSENT));
      post_mask[i] = (st_nxt[i] == rrsl_pkg::SS_RUNNABLE);
    end
  end

  rrsl_pick #(.N(NUM_SLOTS)) u_pick_req (
    .mask (req_mask),
    .last (last_r),
    .res  (pick_req)
  );

  rrsl_pick #(.N(NUM_SLOTS)) u_pick_post (
    .mask (post_mask),
    .last (last_nxt),
    .res  (pick_post)
  );

  always_comb begin
    st_nxt     = st_r;
    hv_nxt     = hv_r;
    holder_nxt = holder_r;
    depth_nxt  = depth_r;
    last_nxt   = last_r;
    status     = rrsl_pkg::STAT_OK;
    try_grant  = 1'b0;
    try_drop   = 1'b0;
    out_nxt    = '0;

    if (!id_ok) begin
      status = (cmd == rrsl_pkg::CMD_QUERY) ? rrsl_pkg::STAT_OK : rrsl_pkg::STAT_NOT_HOLDER;
    end else begin
      case (cmd)
        rrsl_pkg::CMD_ACQUIRE: begin
          if (is_holder) begin
            try_grant = 1'b1;
          end else if (hv_r || (st_cur == rrsl_pkg::SS_WAITING)) begin
            status = rrsl_pkg::STAT_MUST_WAIT;
          end else if (!pick_req.valid || (pick_req.idx == sid)) begin
            try_grant = 1'b1;
          end else begin
            status = rrsl_pkg::STAT_MUST_WAIT;
          end
        end
        rrsl_pkg::CMD_WAKE_ACQUIRE: begin
          if (is_holder || (!hv_r && (st_cur != rrsl_pkg::SS_WAITING))) begin
            try_grant = 1'b1;
          end else begin
            status = rrsl_pkg::STAT_MUST_WAIT;
          end
        end
        rrsl_pkg::CMD_RELEASE: begin
          if (!is_holder) begin
            status = rrsl_pkg::STAT_NOT_HOLDER;
          end else if (depth_r == '0) begin
            status = rrsl_pkg::STAT_ZERO_DEPTH;
          end else begin
            try_drop = 1'b1;
          end
        end
        rrsl_pkg::CMD_YIELD_WAIT: begin
          if (!is_holder) begin
            status = rrsl_pkg::STAT_NOT_HOLDER;
          end else if (depth_r == '0) begin
            status = rrsl_pkg::STAT_ZERO_DEPTH;
          end else begin
            hv_nxt       = 1'b0;
            holder_nxt   = '0;
            depth_nxt    = '0;
            last_nxt     = sid;
            st_nxt[slot] = rrsl_pkg::SS_WAITING;
          end
        end
        rrsl_pkg::CMD_RESUME: begin
          st_nxt[slot] = rrsl_pkg::SS_RUNNABLE;
        end
        rrsl_pkg::CMD_RETIRE: begin
          st_nxt[slot] = rrsl_pkg::SS_ABSENT;
          if (is_holder) begin
            hv_nxt     = 1'b0;
            holder_nxt = '0;
            depth_nxt  = '0;
            last_nxt   = sid;
          end
        end
        rrsl_pkg::CMD_LENIENT_RELEASE: begin
          if (is_holder && (depth_r != '0)) begin
            try_drop = 1'b1;
          end else if (!hv_r && (st_cur == rrsl_pkg::SS_WAITING)) begin
            st_nxt[slot] = rrsl_pkg::SS_RUNNABLE;
          end
        end
        default: begin
        end
      endcase

      // A grant happens only for the holder or on a free lock, so a held lock
      // here always belongs to the requester.
      if (try_grant) begin
        if (hv_r && (depth_r == DEPTH_MAX)) begin
          status = rrsl_pkg::STAT_OVERFLOW;
        end else begin
          hv_nxt       = 1'b1;
          holder_nxt   = sid;
          depth_nxt    = (hv_r ? depth_r : '0) + DEPTH_BITS'(1);
          st_nxt[slot] = rrsl_pkg::SS_RUNNING;
        end
      end

      if (try_drop) begin
        if (depth_dec == '0) begin
          hv_nxt       = 1'b0;
          holder_nxt   = '0;
          depth_nxt    = '0;
          last_nxt     = sid;
          st_nxt[slot] = rrsl_pkg::SS_RUNNABLE;
        end else begin
          depth_nxt = depth_dec;
        end
      end
    end

    out_nxt.granted        = try_grant && (status == rrsl_pkg::STAT_OK);
    out_nxt.status         = status;
    out_nxt.holder_valid   = hv_nxt;
    out_nxt.holder_session = hv_nxt ? holder_nxt : '0;
    if (!id_ok) begin
      out_nxt.session_status = rrsl_pkg::RPT_RUNNABLE;
    end else begin
      case (st_nxt[slot])
        rrsl_pkg::SS_RUNNING: out_nxt.session_status = rrsl_pkg::RPT_RUNNING;
        rrsl_pkg::SS_WAITING: out_nxt.session_status = rrsl_pkg::RPT_WAITING;
        default:              out_nxt.session_status = rrsl_pkg::RPT_RUNNABLE;
      endcase
    end
    out_nxt.next_valid   = pick_post.valid;
    out_nxt.next_session = pick_post.valid ? pick_post.idx : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r <= in_ch.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_r[i] <= rrsl_pkg::SS_ABSENT;
      end
      hv_r     <= 1'b0;
      holder_r <= '0;
      depth_r  <= '0;
      last_r   <= '0;
    end else if (advance) begin
      st_r     <= st_nxt;
      hv_r     <= hv_nxt;
      holder_r <= holder_nxt;
      depth_r  <= depth_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_nxt;
    end
  end

  `RRSL_ASSERT_IMP(a_free_is_clean, !hv_r, (holder_r == '0) && (depth_r == '0))
  `RRSL_ASSERT_IMP(a_held_has_depth, hv_r, depth_r != '0)
  `RRSL_ASSERT_IMP(a_grant_leaves_holder, out_vld_r && out_item_r.granted, out_item_r.holder_valid && (out_item_r.status == rrsl_pkg::STAT_OK))
  `RRSL_ASSERT_NEXT(a_result_follows, advance, out_vld_r)

endmodule

`default_nettype wire
